FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the noise hash RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/core/cnh_pkg.sv
// Types and constants of the chained coordinate noise hash.
`timescale 1ns / 1ps
package cnh_pkg;

  localparam int FRAC_BITS = 30;
  localparam int SUM_W     = 35;
  localparam int MAG_SPLIT = 17;
  localparam int HASH_SHIFT = 13;

  localparam logic [31:0] FEEDBACK_GAIN = 32'd850000;
  localparam logic [31:0] HASH_MUL_A    = 32'd15731;
  localparam logic [31:0] HASH_ADD_A    = 32'd789221;
  localparam logic [31:0] HASH_ADD_B    = 32'd1376312589;
  localparam logic [SUM_W-1:0] ONE_FIXED = SUM_W'(64'd1 << FRAC_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB_LO,
    ST_FB_HI,
    ST_FB_SUM,
    ST_SQUARE,
    ST_MUL_A,
    ST_MUL_B,
    ST_ACCUM
  } state_t;

  typedef enum logic [2:0] {
    MSEL_FB_LO,
    MSEL_FB_HI,
    MSEL_SQUARE,
    MSEL_MUL_A,
    MSEL_MUL_B
  } mul_sel_t;

  typedef struct packed {
    logic     ready;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     load_lo;
    logic     load_q;
    logic     load_seed;
    logic     accum;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic out_blocked;
  } status_t;

endpackage

FILE: rtl/core/chained_coordinate_noise_hash.sv
// Top level of the chained coordinate noise hash.
// The block accepts one coordinate of a grid point per transfer and holds a running sum with
// 30 fraction bits; the coordinate flagged last, or the MAX_DIMS-th one, ends the point and
// makes one result transfer. Each coordinate occupies the block from its transfer to the next
// readiness: the transfer, then five products on the single 32 by 32 bit multiplier, two for
// the sum feedback and, after a step that reduces the feedback, three for the hash, and last
// a step to accumulate. The accumulate step waits while an earlier result still sits
// untaken in the output register and the current coordinate ends a point.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module chained_coordinate_noise_hash #(
  parameter int MAX_DIMS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [15:0] coord,
  input  logic        last_coord,
  output logic        result_valid,
  input  logic        result_stall,
  output logic signed [cnh_pkg::SUM_W-1:0] noise_value
);
  import cnh_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIMS + 1);

  ctrl_t   ctl;
  status_t status;

  logic [15:0]       coord_r;
  logic              last_r;
  logic [SUM_W-1:0]  noise_sum;
  logic [CNT_W-1:0]  coord_count;
  logic [CNT_W-1:0]  count_next;
  logic [36:0]       fb_lo;
  logic [23:0]       fb_q;
  logic [31:0]       s1;

  logic              sum_neg;
  logic [SUM_W-1:0]  sum_mag;
  logic [53:0]       fb_total;
  logic [31:0]       fb_signed;
  logic [31:0]       seed;
  logic [31:0]       s1_comb;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       prod;
  logic [31:0]       hash;
  logic [SUM_W-1:0]  term;
  logic [SUM_W-1:0]  sum_new;
  logic              finish;

  assign item_stall     = !ctl.ready;
  assign status.in_fire = item_valid && ctl.ready;

  assign sum_neg   = noise_sum[SUM_W-1];
  assign sum_mag   = sum_neg ? (SUM_W'(0) - noise_sum) : noise_sum;
  assign fb_total  = {prod[36:0], MAG_SPLIT'(0)} + 54'(fb_lo);
  assign fb_signed = sum_neg ? (32'd0 - 32'(fb_q)) : 32'(fb_q);
  assign seed      = 32'(coord_r) + fb_signed;
  assign s1_comb   = (seed << HASH_SHIFT) ^ seed;

  assign hash     = prod[31:0] + HASH_ADD_B;
  assign term     = ONE_FIXED - SUM_W'(hash[30:0]);
  assign sum_new  = noise_sum + term;
  assign count_next = coord_count + CNT_W'(1);
  assign finish   = last_r || (count_next == CNT_W'(MAX_DIMS));
  assign status.out_blocked = finish && result_valid && result_stall;

  always_comb begin
    unique case (ctl.mul_sel)
      MSEL_FB_LO: begin
        mul_a = 32'(sum_mag[MAG_SPLIT-1:0]);
        mul_b = FEEDBACK_GAIN;
      end
      MSEL_FB_HI: begin
        mul_a = 32'(sum_mag[2*MAG_SPLIT-1:MAG_SPLIT]);
        mul_b = FEEDBACK_GAIN;
      end
      MSEL_SQUARE: begin
        mul_a = s1_comb;
        mul_b = s1_comb;
      end
      MSEL_MUL_A: begin
        mul_a = prod[31:0];
        mul_b = HASH_MUL_A;
      end
      MSEL_MUL_B: begin
        mul_a = s1;
        mul_b = prod[31:0] + HASH_ADD_A;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cnh_mul u_mul (
    .clk (clk),
    .en  (ctl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  cnh_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl)
  );

  always_ff @(posedge clk) begin
    if (status.in_fire) begin
      coord_r <= coord;
      last_r  <= last_coord;
    end
    if (ctl.load_lo) begin
      fb_lo <= prod[36:0];
    end
    if (ctl.load_q) begin
      fb_q <= fb_total[53:FRAC_BITS];
    end
    if (ctl.load_seed) begin
      s1 <= s1_comb;
    end
    if (ctl.accum && finish) begin
      noise_value <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_sum    <= '0;
      coord_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (ctl.accum) begin
        if (finish) begin
          noise_sum   <= '0;
          coord_count <= '0;
        end else begin
          noise_sum   <= sum_new;
          coord_count <= count_next;
        end
      end
      if (ctl.accum && finish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  `ASSERT_AT(a_count_range, clk, rst, coord_count < CNT_W'(MAX_DIMS), "Coordinate count overran.")
  `ASSERT_AT(a_result_src, clk, rst, $rose(result_valid) |-> $past(ctl.accum), "Result without accumulation.")
  `ASSERT_AT(a_sum_cleared, clk, rst, (ctl.accum && finish) |=> noise_sum == '0, "Sum not cleared at end of point.")

endmodule

FILE: rtl/core/cnh_mul.sv
// Shared 32 by 32 bit unsigned multiplier with a registered product.
`timescale 1ns / 1ps
module cnh_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= 64'(a) * 64'(b);
    end
  end

endmodule

FILE: rtl/core/cnh_ctrl.sv
// Sequencer that steps one coordinate through the shared multiplier.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cnh_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  cnh_pkg::status_t status,
  output cnh_pkg::ctrl_t   ctl
);
  import cnh_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (status.in_fire) state_next = ST_FB_LO;
      ST_FB_LO:  state_next = ST_FB_HI;
      ST_FB_HI:  state_next = ST_FB_SUM;
      ST_FB_SUM: state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_MUL_A;
      ST_MUL_A:  state_next = ST_MUL_B;
      ST_MUL_B:  state_next = ST_ACCUM;
      ST_ACCUM:  if (!status.out_blocked) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.mul_sel = MSEL_FB_LO;
    unique case (state)
      ST_IDLE: ctl.ready = 1'b1;
      ST_FB_LO: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MSEL_FB_LO;
      end
      ST_FB_HI: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MSEL_FB_HI;
        ctl.load_lo = 1'b1;
      end
      ST_FB_SUM: ctl.load_q = 1'b1;
      ST_SQUARE: begin
        ctl.mul_en    = 1'b1;
        ctl.mul_sel   = MSEL_SQUARE;
        ctl.load_seed = 1'b1;
      end
      ST_MUL_A: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MSEL_MUL_A;
      end
      ST_MUL_B: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MSEL_MUL_B;
      end
      ST_ACCUM: ctl.accum = !status.out_blocked;
      default: ctl.ready = 1'b0;
    endcase
  end

  `ASSERT_AT(a_fire_starts, clk, rst, status.in_fire |=> state == ST_FB_LO, "Transfer did not start the sequence.")
  `ASSERT_NEVER(a_fire_busy, clk, rst, status.in_fire && state != ST_IDLE, "Transfer taken while busy.")

endmodule
